// ===== hw/rtl/ccwc_pkg.sv =====
package ccwc_pkg;

  localparam int MAX_TARGET  = 1023;
  localparam int COUNT_WIDTH = 32;
  localparam int DEPTH       = MAX_TARGET + 1;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int VAL_W       = 10;
  localparam int OUT_W       = 32;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [VAL_W-1:0] coin_value;
    logic             last_coin;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] ways_count;
    logic             overflow;
  } out_t;

  // request as classified by the front end
  typedef struct packed {
    logic [ADDR_W-1:0] coin;
    logic [ADDR_W-1:0] tgt;
    logic              sweep;
    logic              last;
  } q_ent_t;

  function automatic logic [ADDR_W-1:0] eff_target(input logic [VAL_W-1:0] t);
    if (int'(t) > MAX_TARGET) begin
      return ADDR_W'(MAX_TARGET);
    end else begin
      return ADDR_W'(t);
    end
  endfunction

endpackage

// ===== hw/rtl/ccwc_ram.sv =====
module ccwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/ccwc_front.sv =====
module ccwc_front import ccwc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_t              item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VAL_W-1:0] cfg_data,
  input  logic             init_busy,
  output logic             q_vld,
  output q_ent_t           q_ent,
  input  logic             q_pop
);

  logic [VAL_W-1:0]  target;
  q_ent_t            slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  q_ent_t            ent_new;
  logic [ADDR_W-1:0] tgt;

  assign cfg_ready = 1'b1;
  assign busy      = (count == 2'd2) || init_busy;
  assign push      = start && !busy;
  assign q_vld     = (count != 2'd0);
  assign q_ent     = slots[rd_ptr];

  always_comb begin
    tgt           = eff_target(target);
    ent_new.tgt   = tgt;
    ent_new.coin  = ADDR_W'(item.coin_value);
    ent_new.sweep = (item.coin_value != '0) && (int'(item.coin_value) <= int'(tgt));
    ent_new.last  = item.last_coin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        target <= cfg_data;
      end
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= ent_new;
    end
  end

endmodule

// ===== hw/rtl/ccwc_back.sv =====
module ccwc_back import ccwc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_vld,
  input  q_ent_t q_ent,
  output logic   q_pop,
  output logic   init_busy,
  output logic   done,
  output out_t   result
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;

  logic [2:0]             st;
  logic [ADDR_W-1:0]      v;
  logic [ADDR_W-1:0]      coin;
  logic [ADDR_W-1:0]      tgt;
  logic                   last;
  logic                   sat;
  logic                   init;
  logic                   p_vld;
  logic [ADDR_W-1:0]      p_addr;
  logic [ADDR_W-1:0]      ra;
  logic [ADDR_W-1:0]      rb;
  logic [ADDR_W-1:0]      ra_q;
  logic [ADDR_W-1:0]      rb_q;
  logic [COUNT_WIDTH-1:0] rd_a;
  logic [COUNT_WIDTH-1:0] rd_b;
  logic [COUNT_WIDTH-1:0] fa;
  logic [COUNT_WIDTH-1:0] fb;
  logic [COUNT_WIDTH:0]   sum;
  logic                   sum_ovf;
  logic                   fwd_vld;
  logic [ADDR_W-1:0]      fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [COUNT_WIDTH-1:0] wdata;

  assign init_busy = init;
  assign q_pop     = (st == ST_IDLE) && q_vld;
  assign ra        = (st == ST_RD) ? tgt : v;
  assign rb        = v - coin;

  // last write lands on the same edge as the read that follows it
  assign fa = (fwd_vld && fwd_addr == ra_q) ? fwd_data : rd_a;
  assign fb = (fwd_vld && fwd_addr == rb_q) ? fwd_data : rd_b;

  assign sum     = {1'b0, fa} + {1'b0, fb};
  assign sum_ovf = sum[COUNT_WIDTH];

  always_comb begin
    we    = p_vld || (st == ST_CLEAR);
    waddr = p_vld ? p_addr : v;
    if (p_vld) begin
      wdata = sum_ovf ? CNT_MAX : sum[COUNT_WIDTH-1:0];
    end else begin
      wdata = (v == '0) ? COUNT_WIDTH'(1) : '0;
    end
  end

  ccwc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign done              = (st == ST_EMIT);
  assign result.ways_count = OUT_W'(fa);
  assign result.overflow   = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_CLEAR;
      v       <= '0;
      init    <= 1'b1;
      sat     <= 1'b0;
      p_vld   <= 1'b0;
      fwd_vld <= 1'b0;
    end else begin
      p_vld   <= (st == ST_SWEEP);
      fwd_vld <= we;
      if (p_vld && sum_ovf) begin
        sat <= 1'b1;
      end
      case (st)
        ST_IDLE: begin
          if (q_vld) begin
            coin <= q_ent.coin;
            tgt  <= q_ent.tgt;
            last <= q_ent.last;
            v    <= q_ent.coin;
            if (q_ent.sweep) begin
              st <= ST_SWEEP;
            end else if (q_ent.last) begin
              st <= ST_RD;
            end
          end
        end
        ST_SWEEP: begin
          if (v == tgt) begin
            st <= last ? ST_RD : ST_IDLE;
          end else begin
            v <= v + ADDR_W'(1);
          end
        end
        ST_RD: begin
          st <= ST_EMIT;
        end
        ST_EMIT: begin
          sat <= 1'b0;
          v   <= '0;
          st  <= ST_CLEAR;
        end
        ST_CLEAR: begin
          if (v == ADDR_W'(MAX_TARGET)) begin
            st   <= ST_IDLE;
            init <= 1'b0;
          end else begin
            v <= v + ADDR_W'(1);
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_addr   <= v;
    ra_q     <= ra;
    rb_q     <= rb;
    fwd_addr <= waddr;
    fwd_data <= wdata;
  end

endmodule

// ===== hw/rtl/coin_change_way_counter_core.sv =====
// Coin change way counter.
// Set target_value through the cfg channel (cfg_data, cfg_valid/cfg_ready) while idle.
// Then send denominations one per request: a request is taken on a clock edge with
// start high and busy low; item.last_coin marks the final coin of the set.
// A request queue of two entries sits in front of the table engine, so busy only
// rises when it is full or during the initial table clear.
// An idle engine pops a request in the cycle after it is taken.
// A coin c with 1 <= c <= target sweeps table entries c..target, bounded by one
// table read-modify-write per cycle on the dual-read table RAM; others skip it.
// The last coin adds a result read, then the cycle in which done pulses
// with result.ways_count and result.overflow. The receiver cannot stall; the
// result must be taken in that cycle.
// After each result all 1024 table entries are cleared, one entry a cycle,
// overlapped with queueing of the next set's coins.
// After reset the table is cleared the same way with busy held high;
// target resets to 0.
module coin_change_way_counter_core import ccwc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_t              item,
  output logic             done,
  output out_t             result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VAL_W-1:0] cfg_data
);

  logic   q_vld;
  q_ent_t q_ent;
  logic   q_pop;
  logic   init_busy;

  ccwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .init_busy (init_busy),
    .q_vld     (q_vld),
    .q_ent     (q_ent),
    .q_pop     (q_pop)
  );

  ccwc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_vld     (q_vld),
    .q_ent     (q_ent),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .done      (done),
    .result    (result)
  );

endmodule
